// ----- design/rfr_pkg.sv -----
// Package: shared types, event codes and the byte-wide CRC-16/ARC update.
`timescale 1ns / 1ps

package rfr_pkg;

    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] BYTE_MASK    = 16'h00FF;
    localparam logic [6:0]  HDR_LEN_MASK = 7'b1111111;
    localparam int          CRC_BITS     = 8;

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_HDR_OK  = 3'd1,
        EV_HDR_REJ = 3'd2,
        EV_BODY    = 3'd3,
        EV_CRC_OK  = 3'd4,
        EV_CRC_BAD = 3'd5,
        EV_ARMED   = 3'd6
    } event_t;

    typedef enum logic {
        REQ_ARM  = 1'b0,
        REQ_BYTE = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] out_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_total;
        logic       still_waiting;
    } out_item_t;

    // Reflected CRC-16, one byte per call, LSB first.
    function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ ({8'h00, data} & BYTE_MASK);
        for (int k = 0; k < CRC_BITS; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- design/rfr_channels.sv -----
// Interfaces: valid/ready channels for incoming requests and results.
`timescale 1ns / 1ps

interface rfr_item_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, req_type, rx_byte, input ready);
    modport sink   (input valid, req_type, rx_byte, output ready);
endinterface

interface rfr_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_total;
    logic       still_waiting;

    modport source (output valid, event_res, out_byte, byte_index, frame_total,
                    still_waiting, input ready);
    modport sink   (input valid, event_res, out_byte, byte_index, frame_total,
                    still_waiting, output ready);
endinterface

// ----- design/rfr_frame_ctrl.sv -----
// Frame tracking: arm flag, frame counters, running CRC and result decode.
`timescale 1ns / 1ps

module rfr_frame_ctrl
    import rfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  in_item,
    output out_item_t result
);

    logic        awaiting_reply_reg, awaiting_reply_next;
    logic        in_frame_reg, in_frame_next;
    logic [7:0]  received_count_reg, received_count_next;
    logic [7:0]  data_len_plus_one_reg, data_len_plus_one_next;
    logic [15:0] running_crc_reg, running_crc_next;

    logic [15:0] crc_upd;
    logic [7:0]  count_inc;
    logic [8:0]  last_count;

    assign crc_upd    = crc16_step(in_frame_reg ? running_crc_reg : 16'h0000,
                                   in_item.rx_byte);
    assign count_inc  = received_count_reg + 8'd1;
    assign last_count = {1'b0, data_len_plus_one_reg} + 9'd3;

    always_comb
    begin
        awaiting_reply_next    = awaiting_reply_reg;
        in_frame_next          = in_frame_reg;
        received_count_next    = received_count_reg;
        data_len_plus_one_next = data_len_plus_one_reg;
        running_crc_next       = running_crc_reg;
        result.event_res       = EV_IGNORED;
        result.out_byte        = 8'd0;
        result.byte_index      = 8'd0;
        result.frame_total     = 8'd0;

        if (in_item.req_type == REQ_ARM)
        begin
            awaiting_reply_next = 1'b1;
            result.event_res    = EV_ARMED;
        end
        else if (awaiting_reply_reg)
        begin
            if (!in_frame_reg)
            begin
                if (!in_item.rx_byte[7])
                begin
                    data_len_plus_one_next = {1'b0, in_item.rx_byte[6:0] & HDR_LEN_MASK}
                                             + 8'd1;
                    received_count_next    = 8'd1;
                    in_frame_next          = 1'b1;
                    running_crc_next       = crc_upd;
                    result.event_res       = EV_HDR_OK;
                    result.out_byte        = in_item.rx_byte;
                    result.frame_total     = data_len_plus_one_next + 8'd2;
                end
                else
                begin
                    data_len_plus_one_next = 8'd0;
                    received_count_next    = 8'd0;
                    result.event_res       = EV_HDR_REJ;
                end
            end
            else
            begin
                result.byte_index   = received_count_reg;
                result.out_byte     = in_item.rx_byte;
                result.frame_total  = data_len_plus_one_reg + 8'd2;
                running_crc_next    = crc_upd;
                received_count_next = count_inc;
                if ({1'b0, count_inc} == last_count)
                begin
                    in_frame_next          = 1'b0;
                    data_len_plus_one_next = 8'd0;
                    if (crc_upd == 16'h0000)
                    begin
                        awaiting_reply_next = 1'b0;
                        result.event_res    = EV_CRC_OK;
                    end
                    else
                    begin
                        received_count_next = 8'd0;
                        result.event_res    = EV_CRC_BAD;
                    end
                end
                else
                begin
                    result.event_res = EV_BODY;
                end
            end
        end

        result.still_waiting = awaiting_reply_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reply_reg    <= 1'b0;
            in_frame_reg          <= 1'b0;
            received_count_reg    <= 8'd0;
            data_len_plus_one_reg <= 8'd0;
            running_crc_reg       <= 16'h0000;
        end
        else if (accept)
        begin
            awaiting_reply_reg    <= awaiting_reply_next;
            in_frame_reg          <= in_frame_next;
            received_count_reg    <= received_count_next;
            data_len_plus_one_reg <= data_len_plus_one_next;
            running_crc_reg       <= running_crc_next;
        end
    end

    // A frame is only ever open while a reply is awaited.
    a_frame_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> awaiting_reply_reg)
        else $error("frame open while not armed");

    a_frame_len_set: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (data_len_plus_one_reg != 8'd0))
        else $error("frame open with zero length");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> ({1'b0, received_count_reg} < last_count))
        else $error("byte count ran past frame end");

    a_arm_sets_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.req_type == REQ_ARM) |=> awaiting_reply_reg)
        else $error("arm request did not set waiting");

    a_good_frame_ends_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.event_res == EV_CRC_OK) |=> !awaiting_reply_reg && !in_frame_reg)
        else $error("good frame did not end waiting");

endmodule

// ----- design/rfr_out_reg.sv -----
// Result register: holds one result until the sink takes it.
`timescale 1ns / 1ps

module rfr_out_reg
    import rfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  out_item_t           load_data,
    output logic                can_load,
    rfr_result_if.source        res
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    // Slot frees up in the same cycle the sink takes the current result.
    assign can_load   = !valid_reg || res.ready;
    assign valid_next = load || (valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign res.valid         = valid_reg;
    assign res.event_res     = data_reg.event_res;
    assign res.out_byte      = data_reg.out_byte;
    assign res.byte_index    = data_reg.byte_index;
    assign res.frame_total   = data_reg.frame_total;
    assign res.still_waiting = data_reg.still_waiting;

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result overwritten before it was taken");

    a_stall_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !res.ready) |=> valid_reg && $stable(data_reg))
        else $error("stalled result lost");

    a_load_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

endmodule

// ----- design/response_frame_receiver_crc16.sv -----
// Top level: UART response frame receiver with CRC-16/ARC check.
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+------------------------------------------------
//  item     | in  | valid/ready | req_type, rx_byte
//  result   | out | valid/ready | event_res, out_byte, byte_index, frame_total,
//           |     |             | still_waiting
//
// One request per cycle while item.ready is high; its result appears in the result
// register the next cycle. The byte-wide CRC update and frame decode sit before it.
// item.ready is low only while a result is held and result.ready is low.
// Reset clears the arm flag, frame state and CRC; no result is pending after reset.
`timescale 1ns / 1ps

module response_frame_receiver_crc16
    import rfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rfr_item_if.sink      item,
    rfr_result_if.source  result
);

    in_item_t  in_item;
    out_item_t frame_res;
    logic      can_load;
    logic      accept;

    assign in_item.req_type = item.req_type;
    assign in_item.rx_byte  = item.rx_byte;
    assign item.ready       = can_load;
    assign accept           = item.valid && can_load;

    rfr_frame_ctrl u_frame_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .result  (frame_res)
    );

    rfr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .load_data (frame_res),
        .can_load  (can_load),
        .res       (result)
    );

endmodule
